// ===== rtl/fpcs_pkg.sv =====
// Shared widths, types, register codes and helpers for the fixed-pattern correction block.
package fpcs_pkg;

  localparam int DIM_BITS      = 10;
  localparam int TEMP_BITS     = 16;
  localparam int BIAS_BITS     = 10;
  localparam int CFG_DATA_BITS = 11;
  localparam int CFG_IDX_BITS  = 1;

  typedef logic [DIM_BITS-1:0]         dim_t;
  typedef logic [DIM_BITS:0]           ext_dim_t;
  typedef logic signed [TEMP_BITS-1:0] temp_t;
  typedef logic signed [BIAS_BITS-1:0] bias_t;
  typedef logic [CFG_DATA_BITS-1:0]    cfg_data_t;

  localparam temp_t TEMP_MAX = {1'b0, {(TEMP_BITS-1){1'b1}}};
  localparam temp_t TEMP_MIN = {1'b1, {(TEMP_BITS-1){1'b0}}};

  localparam cfg_data_t FRAME_WIDTH_RESET  = CFG_DATA_BITS'(320);
  localparam cfg_data_t FRAME_HEIGHT_RESET = CFG_DATA_BITS'(240);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  // Clamp a programmed dimension to 1 .. 2^DIM_BITS.
  function automatic ext_dim_t eff_dim(input cfg_data_t r);
    ext_dim_t d;
    if (r == '0) begin
      d = ext_dim_t'(1);
    end else if (int'(r) > (1 << DIM_BITS)) begin
      d = ext_dim_t'(1 << DIM_BITS);
    end else begin
      d = ext_dim_t'(r);
    end
    return d;
  endfunction

endpackage

// ===== rtl/fpcs_if.sv =====
// Stream interfaces: pixel input, result output and configuration write channel.
interface fpcs_pix_if import fpcs_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t pixel_temp;
  bias_t pixel_bias;

  modport source (output valid, pixel_temp, pixel_bias, input ready);
  modport sink   (input valid, pixel_temp, pixel_bias, output ready);
endinterface

interface fpcs_res_if import fpcs_pkg::*; ();
  logic  valid;
  logic  ready;
  temp_t corrected_temp;
  logic  saturated;
  logic  frame_done;
  temp_t min_temp;
  dim_t  min_x;
  dim_t  min_y;
  temp_t max_temp;
  dim_t  max_x;
  dim_t  max_y;
  temp_t center_temp;

  modport source (output valid, corrected_temp, saturated, frame_done, min_temp, min_x, min_y,
                  max_temp, max_x, max_y, center_temp, input ready);
  modport sink   (input valid, corrected_temp, saturated, frame_done, min_temp, min_x, min_y,
                  max_temp, max_x, max_y, center_temp, output ready);
endinterface

interface fpcs_cfg_if import fpcs_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_reg_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/fixed_pattern_correct_with_stats.sv =====
// Fixed-pattern offset correction of a thermal pixel stream with per-frame min/max/center stats.
// An accepted pixel beat passes through the input register, then the result register, to its result beat.
// Throughput: one pixel per cycle; the only limit is the result side taking its beats.
// Per pixel: one 17-bit subtract with clamp, two signed compares and the raster position compares.
// Reset (rst, synchronous, active high) empties both stages, restores 320x240 dimensions and
// clears the raster counters and running statistics.
module fixed_pattern_correct_with_stats import fpcs_pkg::*; (
  input logic        clk,
  input logic        rst,
  fpcs_pix_if.sink   pixel,
  fpcs_res_if.source result,
  fpcs_cfg_if.sink   cfg
);

  // Configuration registers
  cfg_data_t frame_width;
  cfg_data_t frame_height;

  // Input stage
  logic  s1_valid;
  temp_t s1_temp;
  bias_t s1_bias;

  // Result stage
  logic res_valid;

  // Frame state
  dim_t  col_count;
  dim_t  row_count;
  temp_t run_min;
  dim_t  run_min_x;
  dim_t  run_min_y;
  temp_t run_max;
  dim_t  run_max_x;
  dim_t  run_max_y;
  temp_t center_hold;
  logic  first_seen;

  // Datapath
  logic                      res_load;
  logic                      advance;
  logic signed [TEMP_BITS:0] diff;
  temp_t                     corr;
  logic                      sat;
  ext_dim_t                  eff_w;
  ext_dim_t                  eff_h;
  logic                      last_col;
  logic                      last_row;
  logic                      done;
  logic                      at_center;
  logic                      take_min;
  logic                      take_max;
  temp_t                     run_min_next;
  dim_t                      run_min_x_next;
  dim_t                      run_min_y_next;
  temp_t                     run_max_next;
  dim_t                      run_max_x_next;
  dim_t                      run_max_y_next;
  temp_t                     center_hold_next;

  // Handshakes: the result register frees when empty or taken; the input
  // register frees when empty or when it moves into the result register.
  assign res_load     = !res_valid || result.ready;
  assign advance      = s1_valid && res_load;
  assign pixel.ready  = !s1_valid || res_load;
  assign result.valid = res_valid;
  assign cfg.ready    = 1'b1;

  // Configuration writes land directly; the user must send them only while idle; it is not enforced.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RESET;
      frame_height <= FRAME_HEIGHT_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Input register: hold the beat until the result side can take it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.valid && pixel.ready) begin
      s1_temp <= pixel.pixel_temp;
      s1_bias <= pixel.pixel_bias;
    end
  end

  // Correction: subtract the bias one bit wider, then clamp back to range.
  always_comb begin
    diff = (TEMP_BITS+1)'(s1_temp) - (TEMP_BITS+1)'(s1_bias);
    sat  = diff[TEMP_BITS] != diff[TEMP_BITS-1];
    if (!sat) begin
      corr = diff[TEMP_BITS-1:0];
    end else if (diff[TEMP_BITS]) begin
      corr = TEMP_MIN;
    end else begin
      corr = TEMP_MAX;
    end
  end

  // Raster position against the effective dimensions. A count past the last
  // index (dimensions shrunk mid-frame) counts as the last one.
  always_comb begin
    eff_w     = eff_dim(frame_width);
    eff_h     = eff_dim(frame_height);
    last_col  = {1'b0, col_count} >= (eff_w - ext_dim_t'(1));
    last_row  = {1'b0, row_count} >= (eff_h - ext_dim_t'(1));
    done      = last_col && last_row;
    at_center = ({1'b0, col_count} == (eff_w >> 1)) && ({1'b0, row_count} == (eff_h >> 1));
  end

  // Running statistics including the current pixel; the first pixel of a
  // frame always takes both, later ones only when strictly beyond.
  always_comb begin
    take_min = !first_seen || (corr < run_min);
    take_max = !first_seen || (corr > run_max);

    run_min_next   = take_min ? corr      : run_min;
    run_min_x_next = take_min ? col_count : run_min_x;
    run_min_y_next = take_min ? row_count : run_min_y;
    run_max_next   = take_max ? corr      : run_max;
    run_max_x_next = take_max ? col_count : run_max_x;
    run_max_y_next = take_max ? row_count : run_max_y;

    center_hold_next = at_center ? corr : center_hold;
  end

  // Frame state: advance with each pixel, drop everything at frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count   <= '0;
      row_count   <= '0;
      run_min     <= TEMP_MAX;
      run_min_x   <= '0;
      run_min_y   <= '0;
      run_max     <= TEMP_MIN;
      run_max_x   <= '0;
      run_max_y   <= '0;
      center_hold <= '0;
      first_seen  <= 1'b0;
    end else if (advance) begin
      if (done) begin
        col_count   <= '0;
        row_count   <= '0;
        run_min     <= TEMP_MAX;
        run_min_x   <= '0;
        run_min_y   <= '0;
        run_max     <= TEMP_MIN;
        run_max_x   <= '0;
        run_max_y   <= '0;
        center_hold <= '0;
        first_seen  <= 1'b0;
      end else begin
        if (last_col) begin
          col_count <= '0;
          row_count <= row_count + dim_t'(1);
        end else begin
          col_count <= col_count + dim_t'(1);
        end
        run_min     <= run_min_next;
        run_min_x   <= run_min_x_next;
        run_min_y   <= run_min_y_next;
        run_max     <= run_max_next;
        run_max_x   <= run_max_x_next;
        run_max_y   <= run_max_y_next;
        center_hold <= center_hold_next;
        first_seen  <= 1'b1;
      end
    end
  end

  // Result register: statistics show only on the frame's last beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result.corrected_temp <= corr;
      result.saturated      <= sat;
      result.frame_done     <= done;
      result.min_temp       <= done ? run_min_next     : '0;
      result.min_x          <= done ? run_min_x_next   : '0;
      result.min_y          <= done ? run_min_y_next   : '0;
      result.max_temp       <= done ? run_max_next     : '0;
      result.max_x          <= done ? run_max_x_next   : '0;
      result.max_y          <= done ? run_max_y_next   : '0;
      result.center_temp    <= done ? center_hold_next : '0;
    end
  end

`ifndef ASSERT_OFF
  // Outside frame end the statistics fields stay zero.
  a_stats_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.frame_done |->
      result.min_temp == '0 && result.max_temp == '0 && result.center_temp == '0 &&
      result.min_x == '0 && result.min_y == '0 && result.max_x == '0 && result.max_y == '0)
    else $error("statistics nonzero outside frame end");

  // A frame's minimum never exceeds its maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.frame_done |-> result.min_temp <= result.max_temp)
    else $error("frame minimum above maximum");

  // A clamped result sits at one end of the range.
  a_sat_extreme: assert property (@(posedge clk) disable iff (rst)
    res_valid && result.saturated |->
      result.corrected_temp == TEMP_MAX || result.corrected_temp == TEMP_MIN)
    else $error("saturated result not at a range limit");

  // Frame end restarts the raster and the statistics.
  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    advance && done |=> col_count == '0 && row_count == '0 && !first_seen)
    else $error("frame state not cleared after frame end");
`endif

endmodule

// ===== test/fixed_pattern_correct_with_stats_test.sv =====
// Self-checking testbench: fixed-pattern correction with per-frame min/max/center statistics.
`timescale 1ns / 100ps

module fixed_pattern_correct_with_stats_test;
  import fpcs_pkg::*;

  // Cycles without any beat on any channel before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;
  // Extra cycles after the last result; the block's pipeline is two stages deep.
  localparam int DRAIN_CYCLES = 8;
  localparam int RASTER_SPAN  = 1 << DIM_BITS;
  localparam int RANDOM_ITEMS = 60;

  // How a burst of random pixels draws its values.
  typedef enum {
    VAL_FULL,    // any 16-bit temperature, any 10-bit bias
    VAL_EDGE,    // near the rails, so clamping is frequent
    VAL_NARROW,  // a handful of values, so min/max ties are frequent
    VAL_MIXED    // per pixel, one of the above
  } value_style_t;

  typedef struct {
    temp_t corrected_temp;
    logic  saturated;
    logic  frame_done;
    temp_t min_temp;
    dim_t  min_x;
    dim_t  min_y;
    temp_t max_temp;
    dim_t  max_x;
    dim_t  max_y;
    temp_t center_temp;
  } corrected_beat_t;

  logic clk;
  logic rst;

  fpcs_pix_if pix ();
  fpcs_res_if res ();
  fpcs_cfg_if cfg ();

  fixed_pattern_correct_with_stats dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix),
    .result (res),
    .cfg    (cfg)
  );

  // Shadow of the block: programmed dimensions, raster position and running statistics.
  cfg_data_t width_reg;
  cfg_data_t height_reg;
  int        col_pos;
  int        row_pos;
  temp_t     coldest;
  int        coldest_x;
  int        coldest_y;
  temp_t     hottest;
  int        hottest_x;
  int        hottest_y;
  temp_t     center_val;
  bit        frame_open;

  corrected_beat_t corrected_q[$];

  int errors        = 0;
  int pixels_sent   = 0;
  int beats_checked = 0;
  int frames_seen   = 0;
  int sat_seen      = 0;
  int reg_writes    = 0;

  bit quiet       = 1'b0;  // no random idling on either side while set
  int hold_cycles = 0;     // receiver holds off for this many cycles
  bit beat_seen   = 1'b0;  // any channel moved a beat since the last rising edge

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void clear_stats();
    col_pos    = 0;
    row_pos    = 0;
    coldest    = TEMP_MAX;
    coldest_x  = 0;
    coldest_y  = 0;
    hottest    = TEMP_MIN;
    hottest_x  = 0;
    hottest_y  = 0;
    center_val = '0;
    frame_open = 1'b0;
  endfunction

  // Usable dimension: zero acts as one, anything past the raster span acts as the span.
  function automatic int dim_span(cfg_data_t r);
    if (r == '0) return 1;
    if (int'(r) > RASTER_SPAN) return RASTER_SPAN;
    return int'(r);
  endfunction

  function automatic void predict_pixel(temp_t raw, bias_t bias);
    int              diff;
    int              w;
    int              h;
    bit              last_col;
    bit              done;
    corrected_beat_t exp_beat;
    diff = int'(raw) - int'(bias);
    w    = dim_span(width_reg);
    h    = dim_span(height_reg);
    exp_beat = '{default: 0};

    // Clamp the difference to the signed temperature range and flag it.
    if (diff > int'(TEMP_MAX)) begin
      exp_beat.corrected_temp = TEMP_MAX;
      exp_beat.saturated      = 1'b1;
    end else if (diff < int'(TEMP_MIN)) begin
      exp_beat.corrected_temp = TEMP_MIN;
      exp_beat.saturated      = 1'b1;
    end else begin
      exp_beat.corrected_temp = temp_t'(diff);
    end

    // The first pixel of a frame seeds both extremes; later ones must beat them strictly.
    if (!frame_open || exp_beat.corrected_temp < coldest) begin
      coldest   = exp_beat.corrected_temp;
      coldest_x = col_pos;
      coldest_y = row_pos;
    end
    if (!frame_open || exp_beat.corrected_temp > hottest) begin
      hottest   = exp_beat.corrected_temp;
      hottest_x = col_pos;
      hottest_y = row_pos;
    end
    frame_open = 1'b1;

    if (col_pos == w / 2 && row_pos == h / 2) center_val = exp_beat.corrected_temp;

    // A count at or past a shrunken dimension counts as the last column or row.
    last_col = col_pos >= w - 1;
    done     = last_col && row_pos >= h - 1;
    exp_beat.frame_done = done;

    if (done) begin
      exp_beat.min_temp    = coldest;
      exp_beat.min_x       = dim_t'(coldest_x);
      exp_beat.min_y       = dim_t'(coldest_y);
      exp_beat.max_temp    = hottest;
      exp_beat.max_x       = dim_t'(hottest_x);
      exp_beat.max_y       = dim_t'(hottest_y);
      exp_beat.center_temp = center_val;
      clear_stats();
    end else if (last_col) begin
      col_pos = 0;
      row_pos = (row_pos + 1) % RASTER_SPAN;
    end else begin
      col_pos = (col_pos + 1) % RASTER_SPAN;
    end

    if (exp_beat.saturated) sat_seen++;
    corrected_q = {corrected_q, exp_beat};
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors: inputs change only at rising edges, so everything sampled at the
  // falling edge is exactly what the next rising edge will take.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst && pix.valid && pix.ready) begin
      predict_pixel(pix.pixel_temp, pix.pixel_bias);
      pixels_sent++;
      beat_seen = 1'b1;
    end
  end

  function automatic void check_field(string name, logic signed [31:0] expv,
                                      logic signed [31:0] actv);
    if (actv !== expv) begin
      $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endfunction

  always @(negedge clk) begin
    corrected_beat_t exp_beat;
    if (!rst && res.valid && res.ready) begin
      beat_seen = 1'b1;
      if (corrected_q.size() == 0) begin
        $error("result beat with no pixel outstanding (corrected_temp %0d)",
               res.corrected_temp);
        errors++;
      end else begin
        exp_beat = corrected_q.pop_front();
        check_field("corrected_temp", exp_beat.corrected_temp, res.corrected_temp);
        check_field("saturated",      exp_beat.saturated,      res.saturated);
        check_field("frame_done",     exp_beat.frame_done,     res.frame_done);
        check_field("min_temp",       exp_beat.min_temp,       res.min_temp);
        check_field("min_x",          exp_beat.min_x,          res.min_x);
        check_field("min_y",          exp_beat.min_y,          res.min_y);
        check_field("max_temp",       exp_beat.max_temp,       res.max_temp);
        check_field("max_x",          exp_beat.max_x,          res.max_x);
        check_field("max_y",          exp_beat.max_y,          res.max_y);
        check_field("center_temp",    exp_beat.center_temp,    res.center_temp);
        beats_checked++;
        if (exp_beat.frame_done) frames_seen++;
      end
    end
  end

  // Result receiver: random stalls, a steady stretch, and a long hold-off on request.
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      res.ready <= 1'b0;
      hold_cycles--;
    end else if (quiet) begin
      res.ready <= 1'b1;
    end else begin
      res.ready <= ($urandom_range(0, 99) >= 34);
    end
  end

  // Watchdog: end the run if no channel moves for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || beat_seen) idle = 0;
      else idle++;
      beat_seen = 1'b0;
    end
    $display("watchdog: %0d idle cycles, %0d results outstanding", idle, corrected_q.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one pixel beat; return at the rising edge that takes it, valid still high.
  task automatic send_pixel(temp_t raw, bias_t bias);
    while (!quiet && $urandom_range(0, 99) < 34) begin
      pix.valid <= 1'b0;
      @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.pixel_temp <= raw;
    pix.pixel_bias <= bias;
    do @(negedge clk); while (!pix.ready);
    @(posedge clk);
  endtask

  // Drop the pixel stream and wait until every predicted result has come back.
  task automatic settle();
    pix.valid <= 1'b0;
    @(posedge clk);
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register beat; valid is left high so back-to-back writes need no gap.
  task automatic write_reg(cfg_reg_t idx, cfg_data_t value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(negedge clk); while (!cfg.ready);
    beat_seen = 1'b1;
    if (idx == REG_FRAME_WIDTH) width_reg = value;
    else height_reg = value;
    reg_writes++;
    @(posedge clk);
  endtask

  // Reprogram both dimensions while the block is idle; a partial frame carries over.
  task automatic set_dims(int w, int h);
    settle();
    write_reg(REG_FRAME_WIDTH, cfg_data_t'(w));
    write_reg(REG_FRAME_HEIGHT, cfg_data_t'(h));
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic temp_t pick_temp(value_style_t style);
    case (style)
      VAL_EDGE: begin
        if ($urandom_range(0, 1))
          return temp_t'(int'(TEMP_MAX) - int'($urandom_range(0, 600)));
        return temp_t'(int'(TEMP_MIN) + int'($urandom_range(0, 600)));
      end
      VAL_NARROW: return temp_t'(int'($urandom_range(0, 4)) - 2);
      default:    return temp_t'($urandom);
    endcase
  endfunction

  function automatic bias_t pick_bias(value_style_t style);
    case (style)
      VAL_EDGE: begin
        if ($urandom_range(0, 1)) return bias_t'(511 - int'($urandom_range(0, 20)));
        return bias_t'(-512 + int'($urandom_range(0, 20)));
      end
      VAL_NARROW: return bias_t'(int'($urandom_range(0, 2)) - 1);
      default:    return bias_t'($urandom);
    endcase
  endfunction

  task automatic send_burst(int count, value_style_t style);
    value_style_t s;
    for (int i = 0; i < count; i++) begin
      s = style;
      if (style == VAL_MIXED) s = value_style_t'($urandom_range(0, 2));
      send_pixel(pick_temp(s), pick_bias(s));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Clamp edges on both rails and the extremes of both fields, at reset dimensions.
  task automatic test_saturation();
    int raw_list[17]  = '{32767, 32767, 32767, 32256, 32255, -32768, -32768, -32768,
                          -32257, -32256, 0, -1, 0, 0, -1, 12345, -20000};
    int bias_list[17] = '{-512, -1, 0, -511, -512, 511, 1, 0,
                          511, 511, 0, -1, -512, 511, 0, 321, -300};
    for (int i = 0; i < 17; i++) send_pixel(temp_t'(raw_list[i]), bias_t'(bias_list[i]));
  endtask

  // Shrink the frame under a partial one: the column already past the new end, the row at its new last.
  task automatic test_midframe_resize();
    set_dims(4, 3);
    send_burst(6, VAL_FULL);
    set_dims(2, 2);
    send_burst(5, VAL_FULL);
  endtask

  // Ties keep the first position; a frame at either rail still reports its first pixel.
  task automatic test_first_occurrence();
    int seq[6] = '{5, -3, 9, -3, 9, 0};
    set_dims(3, 2);
    for (int i = 0; i < 6; i++) send_pixel(temp_t'(100), bias_t'(0));
    for (int i = 0; i < 6; i++) send_pixel(temp_t'(seq[i]), bias_t'(0));
    for (int i = 0; i < 6; i++) send_pixel(TEMP_MAX, bias_t'(0));
    for (int i = 0; i < 6; i++) send_pixel(TEMP_MIN, bias_t'(0));
  endtask

  // Zero dimensions act as one: at 0x0 and 1x1 every pixel closes its own frame, then 1x3 frames follow.
  task automatic test_tiny_dims();
    set_dims(0, 0);
    send_burst(5, VAL_MIXED);
    set_dims(1, 1);
    send_burst(3, VAL_MIXED);
    set_dims(1, 3);
    send_burst(7, VAL_MIXED);
  endtask

  // An oversized width clamps to the raster span: run just past the center column
  // at half the span, then shrink the width so the next pixel closes the frame.
  task automatic test_largest_dims();
    set_dims(2047, 1);
    send_burst(RASTER_SPAN / 2 + 4, VAL_FULL);
    set_dims(2, 1);
    send_burst(1, VAL_FULL);
  endtask

  // Hold the receiver off while pixels keep coming, so the block fills and stalls.
  task automatic test_backpressure();
    set_dims(8, 4);
    quiet       = 1'b1;
    hold_cycles = 150;
    send_burst(64, VAL_MIXED);
    quiet = 1'b0;
  endtask

  // Random bursts at random, mostly small dimensions; most bursts end mid-frame, so the next
  // resize lands inside a frame. One burst runs with no idling at all.
  task automatic test_random();
    int sent;
    int burst;
    int w;
    int h;
    int base;
    sent  = 0;
    burst = 0;
    base  = pixels_sent;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(0, 2047);
        h = $urandom_range(0, 2);
      end else begin
        w = $urandom_range(1, 12);
        h = $urandom_range(1, 6);
      end
      set_dims(w, h);
      quiet = (burst == 1);
      send_burst($urandom_range(15, 40), value_style_t'($urandom_range(0, 3)));
      quiet = 1'b0;
      sent = pixels_sent - base;
      burst++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    int start_count;
    rst            = 1'b1;
    pix.valid      = 1'b0;
    pix.pixel_temp = '0;
    pix.pixel_bias = '0;
    res.ready      = 1'b0;
    cfg.valid      = 1'b0;
    cfg.index      = REG_FRAME_WIDTH;
    cfg.data       = '0;
    width_reg      = FRAME_WIDTH_RESET;
    height_reg     = FRAME_HEIGHT_RESET;
    clear_stats();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_saturation();
    test_midframe_resize();
    test_first_occurrence();
    test_tiny_dims();
    test_backpressure();
    test_largest_dims();
    start_count = pixels_sent;
    test_random();
    settle();

    $display("Run covered %0d pixels (%0d random), %0d completed frames, %0d clamped results,",
             pixels_sent, pixels_sent - start_count, frames_seen, sat_seen);
    $display("  %0d register writes and %0d result beats checked.", reg_writes, beats_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
